// ===== rtl/escdec_pkg.sv =====
package escdec_pkg;

  // default saturation point of the internal byte counter
  localparam int unsigned MAX_COUNT_DEF = 255;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned LEN_W  = 8;

  // conversion phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_ESC    = 6'b000010,
    PH_XFIRST = 6'b000100,
    PH_HEX    = 6'b001000,
    PH_PREFIX = 6'b010000,
    PH_OCT    = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_HEX = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  // characters with a meaning to the decoder
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_V   = 8'h76;

  // control codes produced by named escapes
  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_HT  = 8'd9;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_VT  = 8'd11;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_CR  = 8'd13;

  typedef struct packed {
    logic            valid;
    logic [3:0]      val;
  } digit_t;

  typedef struct packed {
    status_t            status;
    logic [LEN_W-1:0]   len;
    logic [CHAR_W-1:0]  value;
  } result_t;

  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t d;
    d.valid = 1'b1;
    d.val   = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.val = 4'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d.val = 4'(c - CH_LO_A + 8'd10);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d.val = 4'(c - CH_UP_A + 8'd10);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

endpackage

// ===== rtl/escape_sequence_char_decoder_top.sv =====
// escape sequence character decoder
// decodes one character from the head of a byte string, in the style of a
// c string escape: plain byte, named escape, literal after backslash,
// greedy hex (\x, with an optional 0x prefix) or greedy octal digits
// input stream: one byte per request in s_tdata, s_tuser marks the first
//   byte of a conversion (and abandons any conversion still running)
// output stream: one request per finished conversion carrying the decoded
//   value, the bytes consumed from the string start and a status code
// result: the byte that completes the conversion writes its result into the
//   output register, or into the skid register while the output stalls; a
//   non-digit that ends a number completes it but is not counted
// throughput: one byte per cycle while s_tready is high; all decoding is a
//   single pass of logic from the state registers into the result register
// bytes arriving with no conversion running are dropped without a result
// reset: phase returns to idle, counters clear and the output registers empty
// stall: a two-deep output (result register plus skid register) keeps
//   s_tready high while one result waits; with both full, s_tready drops
//   until m_tready frees a slot
module escape_sequence_char_decoder_top #(
  parameter int unsigned MAX_COUNT = escdec_pkg::MAX_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic [0:0]  s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [7:0] decoded_value, [15:8] consumed_len,
                                 // [17:16] status, [23:18] zero
);

  localparam int unsigned CNT_W = $clog2(MAX_COUNT + 1);
  localparam int unsigned EXT_W = (CNT_W > escdec_pkg::LEN_W) ? CNT_W : escdec_pkg::LEN_W;

  // conversion state
  escdec_pkg::phase_t phase, phase_next;
  logic [7:0]         acc, acc_next;
  logic               ovf, ovf_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               lone, lone_next;

  // output buffering
  escdec_pkg::result_t out_res, skid_res;
  logic                out_valid, skid_valid;

  // result of the current byte
  escdec_pkg::result_t res;
  logic                res_valid;

  logic                accept;
  logic [7:0]          c;
  logic                start;
  escdec_pkg::digit_t  hd;
  logic [CNT_W:0]      sum1, sum2;
  logic [CNT_W-1:0]    cnt_inc1, cnt_inc2;
  logic [11:0]         hex_acc;
  logic [10:0]         oct_acc;
  logic [EXT_W-1:0]    cnt_ext, inc1_ext;
  logic [7:0]          len_now, len_inc1;

  assign accept = s_tvalid && s_tready;
  assign c      = s_tdata;
  assign start  = s_tuser[0];
  assign hd     = escdec_pkg::hex_digit(c);

  // saturating byte count, one and two ahead
  assign sum1     = {1'b0, count} + (CNT_W+1)'(1);
  assign sum2     = {1'b0, count} + (CNT_W+1)'(2);
  assign cnt_inc1 = (sum1 > (CNT_W+1)'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : sum1[CNT_W-1:0];
  assign cnt_inc2 = (sum2 > (CNT_W+1)'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : sum2[CNT_W-1:0];

  // reported length saturates at 255
  assign cnt_ext  = EXT_W'(count);
  assign inc1_ext = EXT_W'(cnt_inc1);
  assign len_now  = (cnt_ext > EXT_W'(255)) ? 8'hFF : cnt_ext[7:0];
  assign len_inc1 = (inc1_ext > EXT_W'(255)) ? 8'hFF : inc1_ext[7:0];

  // next digit folded into the accumulator
  assign hex_acc = {acc, 4'b0000} + 12'(hd.val);
  assign oct_acc = {acc, 3'b000} + 11'(c - escdec_pkg::CH_ZERO);

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    ovf_next   = ovf;
    count_next = count;
    lone_next  = lone;
    res_valid  = 1'b0;
    res.value  = 8'd0;
    res.len    = 8'd0;
    res.status = escdec_pkg::ST_OK;

    if (start) begin
      acc_next   = 8'd0;
      ovf_next   = 1'b0;
      lone_next  = 1'b0;
      count_next = '0;
      phase_next = escdec_pkg::PH_IDLE;
      if (c == escdec_pkg::CH_NUL) begin
        res_valid = 1'b1;
      end else if (c == escdec_pkg::CH_BSLASH) begin
        count_next = CNT_W'(1);
        phase_next = escdec_pkg::PH_ESC;
      end else begin
        res_valid = 1'b1;
        res.value = c;
        res.len   = 8'd1;
      end
    end else begin
      unique case (phase)
        escdec_pkg::PH_ESC: begin
          count_next = cnt_inc1;
          res.len    = len_inc1;
          res_valid  = 1'b1;
          phase_next = escdec_pkg::PH_IDLE;
          unique case (c)
            escdec_pkg::CH_LO_A: res.value = escdec_pkg::CODE_BEL;
            escdec_pkg::CH_LO_B: res.value = escdec_pkg::CODE_BS;
            escdec_pkg::CH_LO_F: res.value = escdec_pkg::CODE_FF;
            escdec_pkg::CH_LO_N: res.value = escdec_pkg::CODE_LF;
            escdec_pkg::CH_LO_R: res.value = escdec_pkg::CODE_CR;
            escdec_pkg::CH_LO_T: res.value = escdec_pkg::CODE_HT;
            escdec_pkg::CH_LO_V: res.value = escdec_pkg::CODE_VT;
            escdec_pkg::CH_LO_X: begin
              res_valid  = 1'b0;
              phase_next = escdec_pkg::PH_XFIRST;
            end
            default: begin
              if (escdec_pkg::is_oct(c)) begin
                res_valid  = 1'b0;
                acc_next   = c - escdec_pkg::CH_ZERO;
                ovf_next   = 1'b0;
                phase_next = escdec_pkg::PH_OCT;
              end else begin
                res.value = c;
              end
            end
          endcase
        end

        escdec_pkg::PH_XFIRST: begin
          if (!hd.valid) begin
            res_valid  = 1'b1;
            res.status = escdec_pkg::ST_NO_HEX;
            phase_next = escdec_pkg::PH_IDLE;
          end else begin
            count_next = cnt_inc1;
            acc_next   = 8'(hd.val);
            ovf_next   = 1'b0;
            lone_next  = (c == escdec_pkg::CH_ZERO);
            phase_next = escdec_pkg::PH_HEX;
          end
        end

        escdec_pkg::PH_HEX: begin
          if (hd.valid) begin
            count_next = cnt_inc1;
            acc_next   = hex_acc[7:0];
            if (hex_acc[11:8] != 4'd0) begin
              ovf_next = 1'b1;
            end
            lone_next  = 1'b0;
          end else if (lone && (c == escdec_pkg::CH_LO_X || c == escdec_pkg::CH_UP_X)) begin
            lone_next  = 1'b0;
            phase_next = escdec_pkg::PH_PREFIX;
          end else begin
            res_valid  = 1'b1;
            res.len    = len_now;
            res.value  = ovf ? 8'hFF : acc;
            res.status = ovf ? escdec_pkg::ST_RANGE : escdec_pkg::ST_OK;
            phase_next = escdec_pkg::PH_IDLE;
          end
        end

        escdec_pkg::PH_PREFIX: begin
          if (!hd.valid) begin
            // lone zero before the x is the whole number
            res_valid  = 1'b1;
            res.len    = len_now;
            phase_next = escdec_pkg::PH_IDLE;
          end else begin
            count_next = cnt_inc2;
            acc_next   = 8'(hd.val);
            ovf_next   = 1'b0;
            phase_next = escdec_pkg::PH_HEX;
          end
        end

        escdec_pkg::PH_OCT: begin
          if (escdec_pkg::is_oct(c)) begin
            count_next = cnt_inc1;
            acc_next   = oct_acc[7:0];
            if (oct_acc[10:8] != 3'd0) begin
              ovf_next = 1'b1;
            end
          end else begin
            res_valid  = 1'b1;
            res.len    = len_now;
            res.value  = ovf ? 8'hFF : acc;
            res.status = ovf ? escdec_pkg::ST_RANGE : escdec_pkg::ST_OK;
            phase_next = escdec_pkg::PH_IDLE;
          end
        end

        default: begin
          // idle, byte outside any conversion is dropped
          phase_next = escdec_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= escdec_pkg::PH_IDLE;
      acc   <= 8'd0;
      ovf   <= 1'b0;
      count <= '0;
      lone  <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      acc   <= acc_next;
      ovf   <= ovf_next;
      count <= count_next;
      lone  <= lone_next;
    end
  end

  // output register with skid stage
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (m_tready || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && res_valid;
        end
      end else if (accept && res_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept && res_valid) begin
        out_res <= res;
      end
    end else if (accept && res_valid) begin
      skid_res <= res;
    end
  end

endmodule
